// File: rtl/eslc_pkg.sv
// ---------------------------------------------------------------------------
// eslc_pkg
// Shared constants for the expert slot LRU cache.
// ---------------------------------------------------------------------------
package eslc_pkg;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 2;
   localparam int STAMP_W  = 64;
   localparam int EXPERT_W = 10;
   localparam int TAG_IN_W = 16;
   localparam int BANK_W   = 2;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_HIT     = 2'd0;
   localparam status_type ST_MISS    = 2'd1;
   localparam status_type ST_REPEAT  = 2'd2;
   localparam status_type ST_INVALID = 2'd3;

   localparam logic CMD_ROUTE = 1'b0;
   localparam logic CMD_BEGIN = 1'b1;
endpackage

// File: rtl/eslc_ram.sv
// ---------------------------------------------------------------------------
// eslc_ram
// Generic RAM, one write port and one read port, registered read data.
// ---------------------------------------------------------------------------
module eslc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/expert_slot_lru_cache.sv
// ---------------------------------------------------------------------------
// expert_slot_lru_cache
// Per-bank fully associative LRU cache mapping routed expert ids to slots.
// ---------------------------------------------------------------------------
// After reset the block sweeps the whole entry memory (BANKS*SLOTS entries,
// 768 by default) and takes no item until that is done. A begin item in
// uncached mode also empties its bank before the next item is taken. A
// route item with a bad id or bank goes straight to the result; a repeat
// inside a batch makes one read of the batch map; an uncached first route
// records the id and goes to the result; a cached first route scans the
// bank's entries through the single read port of the entry memory, one
// entry a cycle, stopping at a hit. One result item is held in an output
// register, and the next request is taken while it waits.
module expert_slot_lru_cache
   import eslc_pkg::*;
#(
   parameter int SLOTS          = 256,
   parameter int BANKS          = 3,
   parameter int LAYER_TAG_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // bank[1:0], layer_tag[17:2], expert_id[27:18], zero
   input  logic [1:0]  req_tuser,   // command[0], cached_mode[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // slot[7:0]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   localparam int SW     = $clog2(SLOTS);
   localparam int NENTRY = BANKS * SLOTS;
   localparam int AW     = $clog2(NENTRY);
   localparam int LTB    = LAYER_TAG_BITS;
   localparam int BKW    = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int EW     = 1 + SW + LTB + STAMP_W;
   // entry word: stamp lowest, then tag, expert, valid on top
   localparam int E_TAG  = STAMP_W;
   localparam int E_EXP  = STAMP_W + LTB;
   localparam int E_VLD  = EW - 1;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_MAPRD  = 3'd2;
   localparam logic [2:0] S_MAPDAT = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_WRITE  = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   // request decode
   logic                 in_cmd, in_cached;
   logic [BANK_W-1:0]    in_bank;
   logic [TAG_IN_W-1:0]  in_tag_raw;
   logic [EXPERT_W-1:0]  in_exp;
   logic [LTB+TAG_IN_W-1:0] tag_ext;
   logic [SW+EXPERT_W-1:0]  exp_ext;
   logic                 exp_ok, bank_ok;

   assign in_bank    = req_tdata[1:0];
   assign in_tag_raw = req_tdata[17:2];
   assign in_exp     = req_tdata[27:18];
   assign in_cmd     = req_tuser[0];
   assign in_cached  = req_tuser[1];
   assign tag_ext    = {{LTB{1'b0}}, in_tag_raw};
   assign exp_ext    = {{SW{1'b0}}, in_exp};
   assign exp_ok     = !in_exp[EXPERT_W-1] && (int'(in_exp) < SLOTS);
   assign bank_ok    = int'(in_bank) < BANKS;

   // control and payload registers
   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in, clr_last_ff, clr_last_in;
   logic [BKW-1:0]     bank_ff, bank_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [LTB-1:0]     tag_ff, tag_in;
   logic [SW-1:0]      exp_ff, exp_in;
   logic [SW:0]        rd_cnt_ff, rd_cnt_in;
   logic               pv_ff, pv_in;
   logic [SW-1:0]      pidx_ff, pidx_in;
   logic [SW-1:0]      cand_ff, cand_in;
   logic [STAMP_W-1:0] cand_stamp_ff, cand_stamp_in;
   logic               vdone_ff, vdone_in;
   logic [SW-1:0]      res_slot_ff, res_slot_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOTS-1:0]   seen_ff, seen_in;
   logic [STAMP_W-1:0] clock_ff [BANKS];
   logic [STAMP_W-1:0] clock_in [BANKS];

   // memory ports
   logic          ent_we;
   logic [AW-1:0] ent_waddr, ent_raddr;
   logic [EW-1:0] ent_wdata, ent_rdata;
   logic          map_we;
   logic [SW-1:0] map_waddr, map_wdata, map_rdata;

   eslc_ram #(.WIDTH(EW), .DEPTH(NENTRY)) u_entry_ram (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(ent_wdata),
      .rd_addr(ent_raddr), .rd_data(ent_rdata)
   );

   eslc_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_map_ram (
      .clock(clock), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(map_wdata),
      .rd_addr(exp_ff), .rd_data(map_rdata)
   );

   // fields of the entry coming back from the scan read
   logic               r_vld, r_match;
   logic [STAMP_W-1:0] r_stamp;
   logic [SLOT_W+SW-1:0] res_slot_ext;
   logic               out_free;

   assign r_vld   = ent_rdata[E_VLD];
   assign r_stamp = ent_rdata[STAMP_W-1:0];
   assign r_match = r_vld && (ent_rdata[E_EXP+SW-1:E_EXP] == exp_ff)
                    && (ent_rdata[E_TAG+LTB-1:E_TAG] == tag_ff);
   assign res_slot_ext = {{SLOT_W{1'b0}}, res_slot_ff};
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      clr_last_in   = clr_last_ff;
      bank_in       = bank_ff;
      base_in       = base_ff;
      tag_in        = tag_ff;
      exp_in        = exp_ff;
      rd_cnt_in     = rd_cnt_ff;
      pv_in         = 1'b0;
      pidx_in       = pidx_ff;
      cand_in       = cand_ff;
      cand_stamp_in = cand_stamp_ff;
      vdone_in      = vdone_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      seen_in       = seen_ff;
      clock_in      = clock_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      ent_we        = 1'b0;
      ent_waddr     = clr_addr_ff;
      ent_wdata     = '0;
      ent_raddr     = base_ff + AW'(rd_cnt_ff[SW-1:0]);
      map_we        = 1'b0;
      map_waddr     = exp_ff;
      map_wdata     = res_slot_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // empty one entry a cycle, stamp zero
            ent_we      = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == clr_last_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               bank_in = BKW'({1'b0, in_bank});
               base_in = AW'(int'(in_bank) * SLOTS);
               tag_in  = tag_ext[LTB-1:0];
               exp_in  = exp_ext[SW-1:0];
               if (in_cmd == CMD_BEGIN) begin
                  seen_in = '0;
                  if (!in_cached && bank_ok) begin
                     clr_addr_in = AW'(int'(in_bank) * SLOTS);
                     clr_last_in = AW'(int'(in_bank) * SLOTS + SLOTS - 1);
                     state_in    = S_CLEAR;
                  end
               end else if (!exp_ok || !bank_ok) begin
                  res_slot_in   = '0;
                  res_status_in = ST_INVALID;
                  state_in      = S_FINISH;
               end else if (seen_ff[exp_ext[SW-1:0]]) begin
                  state_in = S_MAPRD;
               end else if (in_cached) begin
                  rd_cnt_in = '0;
                  vdone_in  = 1'b0;
                  state_in  = S_SCAN;
               end else begin
                  // uncached: slot is the id, still recorded for repeats
                  res_slot_in   = exp_ext[SW-1:0];
                  res_status_in = ST_MISS;
                  state_in      = S_WRITE;
                  rd_cnt_in     = '0;
               end
            end
         end
         S_MAPRD: begin
            state_in = S_MAPDAT;
         end
         S_MAPDAT: begin
            res_slot_in   = map_rdata;
            res_status_in = ST_REPEAT;
            state_in      = S_FINISH;
         end
         S_SCAN: begin
            // issue one read a cycle, judge the entry read last cycle
            if (int'(rd_cnt_ff) < SLOTS) begin
               pv_in     = 1'b1;
               pidx_in   = rd_cnt_ff[SW-1:0];
               rd_cnt_in = rd_cnt_ff + (SW+1)'(1);
            end
            if (pv_ff) begin
               if (pidx_ff == '0) begin
                  cand_in       = '0;
                  cand_stamp_in = r_stamp;
               end else if (!vdone_ff) begin
                  if (!r_vld) begin
                     cand_in  = pidx_ff;
                     vdone_in = 1'b1;
                  end else if (r_stamp < cand_stamp_ff) begin
                     cand_in       = pidx_ff;
                     cand_stamp_in = r_stamp;
                  end
               end
               if (r_match) begin
                  res_slot_in   = pidx_ff;
                  res_status_in = ST_HIT;
                  state_in      = S_WRITE;
                  pv_in         = 1'b0;
               end else if (pidx_ff == SW'(SLOTS - 1)) begin
                  res_slot_in   = cand_in;
                  res_status_in = ST_MISS;
                  state_in      = S_WRITE;
                  pv_in         = 1'b0;
               end
            end
         end
         S_WRITE: begin
            // record in the batch; in cached mode stamp the slot
            // (a scan always issues reads, an uncached route clears the count)
            seen_in[exp_ff] = 1'b1;
            map_we          = 1'b1;
            if (rd_cnt_ff != '0) begin
               clock_in[bank_ff] = clock_ff[bank_ff] + STAMP_W'(1);
               ent_we    = 1'b1;
               ent_waddr = base_ff + AW'(res_slot_ff);
               ent_wdata = {1'b1, exp_ff, tag_ff, clock_ff[bank_ff] + STAMP_W'(1)};
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ext[SLOT_W-1:0];
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_last_ff  <= AW'(NENTRY - 1);
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
         rd_cnt_ff    <= '0;
         seen_ff      <= '0;
         for (int b = 0; b < BANKS; b++) begin
            clock_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_last_ff  <= clr_last_in;
         rsp_valid_ff <= rsp_valid_in;
         pv_ff        <= pv_in;
         rd_cnt_ff    <= rd_cnt_in;
         seen_ff      <= seen_in;
         clock_ff     <= clock_in;
      end
      bank_ff       <= bank_in;
      base_ff       <= base_in;
      tag_ff        <= tag_in;
      exp_ff        <= exp_in;
      pidx_ff       <= pidx_in;
      cand_ff       <= cand_in;
      cand_stamp_ff <= cand_stamp_in;
      vdone_ff      <= vdone_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_slot_ff;
   assign rsp_tuser  = rsp_status_ff;

   // no request taken during a sweep or a scan
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR || state_ff == S_SCAN) |-> !req_tready)
      else $error("request accepted while busy");

   // an invalid result always carries slot zero
   a_invalid_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_INVALID) |-> (rsp_slot_ff == '0))
      else $error("invalid result with non-zero slot");

   // a stamped write leaves the entry ram with the bumped clock and the valid bit set
   a_stamp_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && ent_we) |-> ent_wdata[E_VLD])
      else $error("stamp write without valid");

   // a scan ends only in the write step
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && state_in != S_SCAN) |-> (state_in == S_WRITE))
      else $error("scan left without write");
endmodule
